// ----- rtl/cac_pkg.sv -----
// Shared types and constants for the circular array deque core.
`default_nettype none

package cac_pkg;

  localparam int DataW       = 32;
  localparam int IdxW        = 5;
  localparam int CountW      = 5;
  localparam int DefCapacity = 16;

  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_SET    = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [IdxW-1:0]          index;
    logic signed [DataW-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0]  data;
    status_e                  status;
    logic [CountW-1:0]        count;
  } rsp_t;

  // Per-command control broadcast to every cell of the chain.
  typedef struct packed {
    logic                     set_en;
    logic                     ins_en;
    logic                     rem_en;
    logic [IdxW-1:0]          idx;
    logic [DataW-1:0]         value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/cac_cell.sv -----
// One storage cell of the deque chain: holds one element at a fixed logical position.
`default_nettype none

module cac_cell #(
  parameter int POS = 0,
  parameter int PW  = 5
) (
  input  wire logic                       clk_i,
  input  wire cac_pkg::cell_ctrl_t        ctrl_i,
  input  wire logic [cac_pkg::DataW-1:0]  prev_i,
  input  wire logic [cac_pkg::DataW-1:0]  next_i,
  output logic      [cac_pkg::DataW-1:0]  data_o,
  output logic      [cac_pkg::DataW-1:0]  rd_o
);
  import cac_pkg::*;

  localparam int XW = (PW > IdxW) ? PW : IdxW;

  logic [DataW-1:0] data_q, data_d;
  logic [XW-1:0]    idx_x;
  logic [XW-1:0]    pos_x;
  logic             hit;
  logic             above;

  assign idx_x = XW'(ctrl_i.idx);
  assign pos_x = XW'(POS);
  assign hit   = (idx_x == pos_x);
  assign above = (pos_x > idx_x);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.set_en && hit) begin
      data_d = ctrl_i.value;
    end else if (ctrl_i.ins_en) begin
      // open a gap at the index: take the element from the left neighbor
      if (hit) begin
        data_d = ctrl_i.value;
      end else if (above) begin
        data_d = prev_i;
      end
    end else if (ctrl_i.rem_en && (hit || above)) begin
      // close the gap: take the element from the right neighbor
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = hit ? data_q : '0;

endmodule

`default_nettype wire

// ----- rtl/circular_array_deque_core.sv -----
// Top level of the fixed-capacity deque: command register, fill count and the cell chain.
`default_nettype none

// Fixed-capacity deque with get, set, insert-at-index and remove-at-index.
// Elements sit in logical order in a row of CAPACITY cells; an insert or a
// removal moves every element past the index by one cell at once, each cell
// taking its neighbor's value. A beat is accepted when start_i is high and
// busy_o is low, busy_o then stays high for one cycle while the chain
// executes, and the result beat appears on rsp_o with done_o high for
// exactly one cycle in the cycle after that. The result cannot be stalled,
// so sample it whenever done_o is high. A new command may be started in the
// cycle done_o is high; no beat is taken while busy_o is high. rsp_o.data
// carries the element read, the value written or inserted, or the element
// removed, and zero on any error. Errors (bad index, insert into a full
// deque) change nothing. The cells hold no reset value; only positions below
// the fill count are ever read.
module circular_array_deque_core #(
  parameter int CAPACITY = cac_pkg::DefCapacity
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire cac_pkg::req_t req_i,
  output logic               busy_o,
  output logic               done_o,
  output cac_pkg::rsp_t      rsp_o
);
  import cac_pkg::*;

  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CW = (FW > IdxW) ? FW : IdxW;
  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // command register
  logic       exec_q;
  req_t       req_q;
  logic       accept;

  // fill count and result
  logic [FW-1:0] fill_q, fill_d;
  rsp_t          rsp_q, rsp_d;
  logic          done_q;

  logic [CW-1:0] idx_c;
  logic [CW-1:0] fill_c;
  logic          in_range;
  logic          full;
  status_e       status_c;
  cell_ctrl_t    ctrl;

  logic [DataW-1:0] cell_data [CAPACITY];
  logic [DataW-1:0] cell_rd   [CAPACITY];
  logic [DataW-1:0] rd_data;

  assign accept = start_i && !exec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q <= 1'b0;
    end else begin
      exec_q <= accept;
    end
  end

  // hold the command beat for the execute cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // range and capacity checks
  assign idx_c  = CW'(req_q.index);
  assign fill_c = CW'(fill_q);
  assign full   = (fill_q == FW'(CAPACITY));

  always_comb begin
    if (req_q.cmd == CMD_INSERT) begin
      in_range = (idx_c <= fill_c);
    end else begin
      in_range = (idx_c < fill_c);
    end
    if (!in_range) begin
      status_c = ST_RANGE;
    end else if ((req_q.cmd == CMD_INSERT) && full) begin
      status_c = ST_FULL;
    end else begin
      status_c = ST_OK;
    end
  end

  // broadcast to the chain only on a good command
  always_comb begin
    ctrl        = '0;
    ctrl.idx    = req_q.index;
    ctrl.value  = req_q.value;
    if (exec_q && (status_c == ST_OK)) begin
      case (req_q.cmd)
        CMD_SET:    ctrl.set_en = 1'b1;
        CMD_INSERT: ctrl.ins_en = 1'b1;
        CMD_REMOVE: ctrl.rem_en = 1'b1;
        default:    ctrl.set_en = 1'b0;
      endcase
    end
  end

  // the cell chain
  for (genvar p = 0; p < CAPACITY; p++) begin : g_cell
    logic [DataW-1:0] prev_w;
    logic [DataW-1:0] next_w;

    if (p == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = cell_data[p-1];
    end

    if (p == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = cell_data[p+1];
    end

    cac_cell #(
      .POS (p),
      .PW  (PW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[p]),
      .rd_o   (cell_rd[p])
    );
  end

  // only the addressed cell drives a nonzero read word
  always_comb begin
    rd_data = '0;
    for (int p = 0; p < CAPACITY; p++) begin
      rd_data = rd_data | cell_rd[p];
    end
  end

  // next fill count and result beat
  always_comb begin
    fill_d       = fill_q;
    rsp_d.status = status_c;
    rsp_d.data   = '0;
    if (status_c == ST_OK) begin
      case (req_q.cmd)
        CMD_GET: begin
          rsp_d.data = rd_data;
        end
        CMD_SET: begin
          rsp_d.data = req_q.value;
        end
        CMD_INSERT: begin
          rsp_d.data = req_q.value;
          fill_d     = fill_q + FW'(1);
        end
        CMD_REMOVE: begin
          rsp_d.data = rd_data;
          fill_d     = fill_q - FW'(1);
        end
        default: begin
          rsp_d.data = '0;
        end
      endcase
    end
    rsp_d.count = CountW'(fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= exec_q;
      if (exec_q) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy_o = exec_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // an accepted beat always produces a result beat, through the execute register and then the done register
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("accepted command produced no result beat");

  // the fill count never exceeds the capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(CAPACITY))
    else $error("fill count above capacity");

  // a flagged command leaves the fill count untouched
  a_error_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (rsp_q.status != ST_OK)) |-> $stable(fill_q))
    else $error("errored command changed the fill count");

  // the reported count matches the stored fill count
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rsp_q.count == CountW'(fill_q)))
    else $error("reported count differs from fill count");

  // no two commands execute back to back
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_q |=> !exec_q)
    else $error("command executed in consecutive cycles");

endmodule

`default_nettype wire

// ----- test/deque_check_pkg.sv -----
// Scoreboard for the circular deque core: command predictor and result checker.
package deque_check_pkg;

  import cac_pkg::*;

  class deque_scoreboard;

    localparam int Cap = DefCapacity;

    logic [DataW-1:0] cells [Cap];
    int               head_pos;
    int               fill;
    rsp_t             expected_rsp [$];
    int               mismatches;

    function new();
      head_pos   = 0;
      fill       = 0;
      mismatches = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function int slot(int pos);
      return (head_pos + pos) % Cap;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      mismatches++;
    endtask

    // Apply one accepted command to the shadow deque and queue its result.
    function void note_command(req_t cmd_beat);
      rsp_t exp_beat;
      int   idx;
      exp_beat        = '0;
      exp_beat.status = ST_OK;
      idx             = cmd_beat.index;
      if (cmd_beat.cmd == CMD_INSERT) begin
        if (idx > fill) begin
          exp_beat.status = ST_RANGE;
        end else if (fill >= Cap) begin
          exp_beat.status = ST_FULL;
        end else begin
          if (idx < fill / 2) begin
            head_pos = (head_pos + Cap - 1) % Cap;
            for (int k = 0; k < idx; k++) cells[slot(k)] = cells[slot(k + 1)];
          end else begin
            for (int k = fill; k > idx; k--) cells[slot(k)] = cells[slot(k - 1)];
          end
          cells[slot(idx)] = cmd_beat.value;
          fill++;
          exp_beat.data = cmd_beat.value;
        end
      end else if (idx >= fill) begin
        exp_beat.status = ST_RANGE;
      end else begin
        case (cmd_beat.cmd)
          CMD_GET: begin
            exp_beat.data = cells[slot(idx)];
          end
          CMD_SET: begin
            cells[slot(idx)] = cmd_beat.value;
            exp_beat.data    = cmd_beat.value;
          end
          default: begin
            exp_beat.data = cells[slot(idx)];
            if (idx < fill / 2) begin
              for (int k = idx; k > 0; k--) cells[slot(k)] = cells[slot(k - 1)];
              head_pos = (head_pos + 1) % Cap;
            end else begin
              for (int k = idx; k + 1 < fill; k++) cells[slot(k)] = cells[slot(k + 1)];
            end
            fill--;
          end
        endcase
      end
      exp_beat.count = fill[CountW-1:0];
      expected_rsp.push_back(exp_beat);
    endfunction

    // Compare one result beat against the oldest expectation.
    task check_result(rsp_t got);
      rsp_t exp_beat;
      if (expected_rsp.size() == 0) begin
        report($sformatf("unexpected result data=%h status=%0d count=%0d",
                         got.data, got.status, got.count));
      end else begin
        exp_beat = expected_rsp.pop_front();
        if (got.data !== exp_beat.data)
          report($sformatf("data got %h exp %h", got.data, exp_beat.data));
        if (got.status !== exp_beat.status)
          report($sformatf("status got %0d exp %0d", got.status, exp_beat.status));
        if (got.count !== exp_beat.count)
          report($sformatf("count got %0d exp %0d", got.count, exp_beat.count));
      end
    endtask

  endclass

endpackage

// ----- test/testbench.sv -----
// Self-checking testbench for the circular array deque core.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import cac_pkg::*;
  import deque_check_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  deque_scoreboard sb;

  circular_array_deque_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // Free-running 10 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Sample every result beat at the edge that closes its cycle. The values
  // read here are the ones held before the edge, so no race with the core.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result(rsp_o);
    end
  end

  function automatic req_t make_req(cmd_e op, int idx, logic [DataW-1:0] val);
    req_t beat;
    beat.cmd   = op;
    beat.index = idx[IdxW-1:0];
    beat.value = val;
    return beat;
  endfunction

  // Drive one command beat. Hold start low for the requested gap first, then
  // raise it and wait for an edge where busy is low; that edge takes the beat.
  // Start stays high on return so back-to-back beats need no extra step.
  task automatic send_beat(req_t beat, int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= beat;
    do @(posedge clk_i); while (busy_o);
    sb.note_command(beat);
  endtask

  function automatic logic [DataW-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // Build a random command. Grow mode favors inserts, shrink mode removals,
  // so the fill level sweeps between empty and full. Most indexes are legal
  // for the current fill; the rest are noise over the whole 5-bit field.
  function automatic req_t random_req(bit grow);
    req_t beat;
    int   roll;
    int   span;
    roll = $urandom_range(0, 99);
    if (grow) begin
      beat.cmd = roll < 45 ? CMD_INSERT : roll < 60 ? CMD_REMOVE :
                 roll < 80 ? CMD_GET : CMD_SET;
    end else begin
      beat.cmd = roll < 15 ? CMD_INSERT : roll < 60 ? CMD_REMOVE :
                 roll < 80 ? CMD_GET : CMD_SET;
    end
    span = (beat.cmd == CMD_INSERT) ? sb.fill : sb.fill - 1;
    if (span < 0 || $urandom_range(0, 99) < 12) begin
      beat.index = IdxW'($urandom_range(0, 31));
    end else begin
      beat.index = IdxW'($urandom_range(0, span));
    end
    beat.value = pick_value();
    return beat;
  endfunction

  // Directed opening: empty-deque errors, extreme values, fill to capacity
  // with front, back and middle shifts, full-deque errors, then removals.
  task automatic run_directed();
    int idx;
    send_beat(make_req(CMD_GET, 0, 32'h1234_5678), 0);
    send_beat(make_req(CMD_REMOVE, 0, '0), 0);
    send_beat(make_req(CMD_INSERT, 1, 32'h5555_aaaa), 0);
    send_beat(make_req(CMD_INSERT, 0, 32'h8000_0000), 0);
    send_beat(make_req(CMD_INSERT, 1, 32'h7fff_ffff), 0);
    send_beat(make_req(CMD_SET, 0, 32'hffff_ffff), 0);
    for (int i = 0; i < DefCapacity - 2; i++) begin
      case (i % 3)
        0:       idx = 0;
        1:       idx = sb.fill;
        default: idx = sb.fill / 2;
      endcase
      send_beat(make_req(CMD_INSERT, idx, $urandom), 0);
    end
    // Full deque: legal index reports full, index past the end reports range.
    send_beat(make_req(CMD_INSERT, DefCapacity, 32'hdead_beef), 0);
    send_beat(make_req(CMD_INSERT, DefCapacity + 1, 32'hdead_beef), 0);
    send_beat(make_req(CMD_GET, 31, '0), 0);
    send_beat(make_req(CMD_SET, DefCapacity - 1, 32'h7fff_ffff), 0);
    send_beat(make_req(CMD_REMOVE, DefCapacity - 1, '0), 0);
    send_beat(make_req(CMD_REMOVE, 0, '0), 0);
    send_beat(make_req(CMD_REMOVE, 7, '0), 0);
    send_beat(make_req(CMD_GET, 7, '0), 0);
  endtask

  initial begin
    int idle_pct [4];
    int gap;
    int drain;
    bit grow;

    sb = new();
    idle_pct = '{0, 50, 0, 24};

    // Drive every input to a known value before reset releases.
    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    req_i   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // Random phases with varying sender idling; the core cannot stall results,
    // so the receiver side has nothing to vary.
    grow = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < 310; n++) begin
        if (n % 48 == 47) grow = ~grow;
        // Pause halfway through the third phase until every result is back.
        if (phase == 2 && n == 155) begin
          start_i <= 1'b0;
          while (sb.pending() != 0) @(posedge clk_i);
        end
        gap = ($urandom_range(0, 99) < idle_pct[phase]) ? $urandom_range(1, 3) : 0;
        send_beat(random_req(grow), gap);
      end
    end

    // Drop start, then drain outstanding results with a bound.
    start_i <= 1'b0;
    drain = 0;
    while (sb.pending() != 0 && drain < 200) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    end

    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
